[rtl/tlbc_pkg.sv]
// ----------------------------------------------------------------------------
// tlbc_pkg: shared types and constants for the clock-replacement TLB
// Field widths, request/response payloads and the cell chain structures.
// ----------------------------------------------------------------------------
package tlbc_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_BITS   = 20;
  localparam int FRAME_BITS  = 20;
  localparam int CFG_W       = 5;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  virtual_page;
    logic                  is_write;
    logic [FRAME_BITS-1:0] walk_frame;
  } req_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic                  hit;
    logic                  mark_page_dirty;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    hit_total;
  } rsp_t;

  // Priority carry handed from one cell to the next
  typedef struct packed {
    logic head;         // set only into the first cell
    logic hit_seen;
    logic inv_seen;
    logic unused_seen;
  } chain_t;

  // Broadcast to every cell
  typedef struct packed {
    logic                  update;
    logic [PAGE_BITS-1:0]  page;
    logic                  is_write;
    logic [FRAME_BITS-1:0] walk_frame;
    logic                  any_hit;
    logic                  any_inv;
    logic                  any_unused;
  } cmd_t;

endpackage

[rtl/tlbc_cell.sv]
// ----------------------------------------------------------------------------
// tlbc_cell: one TLB entry
// Holds tag, frame and status bits, compares against the page and takes part
// in the priority chain that picks the hit, fill or clock victim slot.
// ----------------------------------------------------------------------------
module tlbc_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            active,
  input  tlbc_pkg::cmd_t                  cmd,
  input  tlbc_pkg::chain_t                chain_in,
  output tlbc_pkg::chain_t                chain_out,
  output logic                            chosen,
  output logic [tlbc_pkg::FRAME_BITS-1:0] frame_sel,
  output logic                            valid_bit
);

  logic                            valid;
  logic                            used;
  logic                            dirty;
  logic [tlbc_pkg::PAGE_BITS-1:0]  tag;
  logic [tlbc_pkg::FRAME_BITS-1:0] frame;

  logic my_hit;
  logic my_inv;
  logic my_unused;
  logic sweep_clear;

  assign my_hit    = active & valid & (tag == cmd.page);
  assign my_inv    = active & ~valid;
  assign my_unused = active & ~used;

  assign chain_out.head        = 1'b0;
  assign chain_out.hit_seen    = chain_in.hit_seen    | my_hit;
  assign chain_out.inv_seen    = chain_in.inv_seen    | my_inv;
  assign chain_out.unused_seen = chain_in.unused_seen | my_unused;

  always_comb begin
    if (cmd.any_hit) begin
      chosen = my_hit & ~chain_in.hit_seen;
    end else if (cmd.any_inv) begin
      chosen = my_inv & ~chain_in.inv_seen;
    end else if (cmd.any_unused) begin
      chosen = my_unused & ~chain_in.unused_seen;
    end else begin
      chosen = chain_in.head;
    end
  end

  // clock sweep clears used bits up to the victim
  assign sweep_clear = ~cmd.any_hit & ~cmd.any_inv & active & ~chain_in.unused_seen;

  assign frame_sel = chosen ? frame : '0;
  assign valid_bit = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      used  <= 1'b0;
      dirty <= 1'b0;
    end else if (cmd.update) begin
      if (chosen) begin
        used <= 1'b1;
        if (cmd.any_hit) begin
          if (cmd.is_write) begin
            dirty <= 1'b1;
          end
        end else begin
          valid <= 1'b1;
          dirty <= cmd.is_write;
        end
      end else if (sweep_clear) begin
        used <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && chosen && !cmd.any_hit) begin
      tag   <= cmd.page;
      frame <= cmd.walk_frame;
    end
  end

endmodule

[rtl/tlb_lookup_clock_replace_unit.sv]
// ----------------------------------------------------------------------------
// tlb_lookup_clock_replace_unit: fully associative TLB, clock replacement
//
//   channel   signals                        direction  payload
//   request   req_valid / req_stall / req    in         tlbc_pkg::req_t
//   response  rsp_valid / rsp_stall / rsp    out        tlbc_pkg::rsp_t
//   config    cfg_wen / cfg_wdata            in         entries_in_use
//
// Each access first registers the request, then runs the compare and
// priority chain across the entry cells, which also updates them.
// One access is in flight at a time; a new request is taken while the
// previous response still waits in the output register.
// A stalled response holds the next access in its input register.
// Reset clears all valid, used and dirty bits and the hit counter at once.
// ----------------------------------------------------------------------------
module tlb_lookup_clock_replace_unit #(
  parameter int TLB_ENTRIES = tlbc_pkg::TLB_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  tlbc_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output tlbc_pkg::rsp_t             rsp,
  input  logic                       cfg_wen,
  input  logic [tlbc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TLB_ENTRIES + 1);
  localparam int CMP_W = (tlbc_pkg::CFG_W > CNT_W) ? tlbc_pkg::CFG_W : CNT_W;
  localparam int SW    = (IDX_W > tlbc_pkg::SLOT_W) ? IDX_W : tlbc_pkg::SLOT_W;

  logic [tlbc_pkg::CFG_W-1:0]   entries_in_use;
  logic [CNT_W-1:0]             n_eff;
  logic                         busy;
  tlbc_pkg::req_t               cur;
  logic [tlbc_pkg::COUNT_W-1:0] hit_counter;
  logic [tlbc_pkg::COUNT_W-1:0] hit_counter_next;
  logic                         proc;

  tlbc_pkg::chain_t             chain [TLB_ENTRIES+1];
  tlbc_pkg::cmd_t               cmd;
  logic [TLB_ENTRIES-1:0]       active;
  logic [TLB_ENTRIES-1:0]       chosen;
  logic [TLB_ENTRIES-1:0]       valid_vec;
  logic [tlbc_pkg::FRAME_BITS-1:0] frame_sel [TLB_ENTRIES];
  logic [tlbc_pkg::FRAME_BITS-1:0] hit_frame;
  logic [IDX_W-1:0]             slot_idx;
  logic [SW-1:0]                slot_w;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= tlbc_pkg::CFG_RESET;
    end else if (cfg_wen) begin
      entries_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (entries_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (CMP_W'(entries_in_use) > CMP_W'(TLB_ENTRIES)) begin
      n_eff = CNT_W'(TLB_ENTRIES);
    end else begin
      n_eff = CNT_W'(CMP_W'(entries_in_use));
    end
  end

  // handshake
  assign req_stall = busy;
  assign proc      = busy & (~rsp_valid | ~rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req_valid && !req_stall) begin
      busy <= 1'b1;
    end else if (proc) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      cur <= req;
    end
  end

  // cell chain
  assign chain[0].head        = 1'b1;
  assign chain[0].hit_seen    = 1'b0;
  assign chain[0].inv_seen    = 1'b0;
  assign chain[0].unused_seen = 1'b0;

  assign cmd.update     = proc;
  assign cmd.page       = cur.virtual_page;
  assign cmd.is_write   = cur.is_write;
  assign cmd.walk_frame = cur.walk_frame;
  assign cmd.any_hit    = chain[TLB_ENTRIES].hit_seen;
  assign cmd.any_inv    = chain[TLB_ENTRIES].inv_seen;
  assign cmd.any_unused = chain[TLB_ENTRIES].unused_seen;

  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_cell
    assign active[k] = CNT_W'(k) < n_eff;

    tlbc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .active    (active[k]),
      .cmd       (cmd),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1]),
      .chosen    (chosen[k]),
      .frame_sel (frame_sel[k]),
      .valid_bit (valid_vec[k])
    );
  end

  always_comb begin
    hit_frame = '0;
    slot_idx  = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      hit_frame = hit_frame | frame_sel[k];
      if (chosen[k]) begin
        slot_idx = slot_idx | IDX_W'(k);
      end
    end
  end

  assign slot_w = SW'(slot_idx);

  always_comb begin
    hit_counter_next = hit_counter;
    if (cmd.any_hit && hit_counter != '1) begin
      hit_counter_next = hit_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter <= '0;
    end else if (proc) begin
      hit_counter <= hit_counter_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (proc) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      rsp.frame           <= cmd.any_hit ? hit_frame : cur.walk_frame;
      rsp.hit             <= cmd.any_hit;
      rsp.mark_page_dirty <= cmd.any_hit & cur.is_write;
      rsp.slot            <= slot_w[tlbc_pkg::SLOT_W-1:0];
      rsp.hit_total       <= hit_counter_next;
    end
  end

  // checks
  a_one_slot: assert property (@(posedge clk) disable iff (rst)
    proc |-> $onehot(chosen))
    else $error("slot pick is not one-hot");

  a_slot_active: assert property (@(posedge clk) disable iff (rst)
    proc |-> ((chosen & ~active) == '0))
    else $error("picked slot outside the active entries");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    proc |=> ((valid_vec & $past(chosen)) == $past(chosen)))
    else $error("picked slot not valid after update");

  a_rsp_loaded: assert property (@(posedge clk) disable iff (rst)
    proc |=> rsp_valid && !busy)
    else $error("finished access did not reach the response register");

  a_held: assert property (@(posedge clk) disable iff (rst)
    busy && rsp_valid && rsp_stall |=> busy && $stable(hit_counter))
    else $error("access moved while the response was stalled");

endmodule
